// File: rtl/core/mme_pkg.sv
package mme_pkg;

    // array geometry
    localparam int MAX_DIM    = 8;
    localparam int ELEM_WIDTH = 16;
    localparam int IDX_W      = 3;
    localparam int DIM_W      = 4;
    localparam int ADDR_W     = $clog2(MAX_DIM * MAX_DIM);

    // datapath widths
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int ACC_W  = PROD_W + $clog2(MAX_DIM);
    localparam int OUT_W  = 32;

    // stream field widths
    localparam int IN_VAL_W  = 16;
    localparam int IN_DATA_W = 24;
    localparam int OUT_DATA_W = 40;

    typedef logic [IDX_W-1:0]              t_idx;
    typedef logic [DIM_W-1:0]              t_dim;
    typedef logic [ADDR_W-1:0]             t_addr;
    typedef logic signed [ELEM_WIDTH-1:0]  t_elem;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;
    typedef logic signed [OUT_W-1:0]       t_out;

    // saturation bounds at accumulator width
    localparam t_acc SAT_MAX = t_acc'({1'b0, {(OUT_W-1){1'b1}}});
    localparam t_acc SAT_MIN = t_acc'($signed({1'b1, {(OUT_W-1){1'b0}}}));

    typedef enum logic [1:0] {
        ACT_WRITE_A = 2'd0,
        ACT_WRITE_B = 2'd1,
        ACT_COMPUTE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        REG_ROWS_A = 2'd0,
        REG_COLS_A = 2'd1,
        REG_ROWS_B = 2'd2,
        REG_COLS_B = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_ERR
    } t_state;

    // element store write request
    typedef struct packed {
        logic  wr_a;
        logic  wr_b;
        t_addr addr;
        t_elem data;
    } t_store_wr;

    // element store read request
    typedef struct packed {
        logic  en;
        t_addr addr_a;
        t_addr addr_b;
    } t_store_rd;

    // row-major address of an element
    function automatic t_addr elem_addr(input t_idx row, input t_idx col);
        elem_addr = t_addr'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
    endfunction

endpackage

// File: rtl/core/mme_store.sv
module mme_store
    import mme_pkg::*;
(
    input  logic      i_clk,
    input  t_store_wr i_wr,
    input  t_store_rd i_rd,
    output t_elem     o_a_data,
    output t_elem     o_b_data
);

    t_elem r_a_mem [MAX_DIM*MAX_DIM];
    t_elem r_b_mem [MAX_DIM*MAX_DIM];
    t_elem r_a_data;
    t_elem r_b_data;

    // write port, one element per transfer
    always_ff @(posedge i_clk) begin
        if (i_wr.wr_a) begin
            r_a_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_wr.wr_b) begin
            r_b_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_a_data <= r_a_mem[i_rd.addr_a];
            r_b_data <= r_b_mem[i_rd.addr_b];
        end
    end

    assign o_a_data = r_a_data;
    assign o_b_data = r_b_data;

endmodule

// File: rtl/core/matrix_multiply_engine_top.sv
// element writes are accepted back to back while the engine is idle
// a compute request walks every product element in turn
// (ca inner-product reads from the element stores, then the multiply-accumulate drains)
// a dimension mismatch skips the reads and returns a single result flagged mismatch and last
// reset is synchronous active low: control clears, dimensions return to 8, stores stay as they are
module matrix_multiply_engine_top
    import mme_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // element stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // elem_row[2:0], elem_col[5:3], elem_value[21:6]
    input  logic [1:0]            i_s_axis_tuser,  // action[1:0]
    // product stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // out_row[2:0], out_col[5:3], out_value[37:6]
    output logic                  o_m_axis_tuser,  // mismatch
    output logic                  o_m_axis_tlast,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [1:0]            i_cfg_index,
    input  logic [DIM_W-1:0]      i_cfg_data
);

    // dimension clamp: zero reads as one, oversize reads as the maximum
    function automatic t_dim eff_dim(input t_dim raw);
        if (raw == '0) begin
            eff_dim = t_dim'(1);
        end else if (raw > t_dim'(MAX_DIM)) begin
            eff_dim = t_dim'(MAX_DIM);
        end else begin
            eff_dim = raw;
        end
    endfunction

    t_dim r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    t_dim ra, ca, rb, cb;

    t_state r_state, n_state;
    t_idx   r_i, n_i, r_j, n_j, r_k, n_k;

    t_store_wr wr;
    t_store_rd rd;
    t_elem     a_rd, b_rd;

    logic  in_xfer, start;
    logic  r_p1_valid, r_p1_first, r_p1_last;
    logic  r_p2_valid, r_p2_first, r_p2_last;
    t_prod r_prod;
    t_acc  r_acc;
    logic  r_acc_done;

    logic  slot_free, load_out, load_err, last_elem;
    t_out  sat_value;

    logic  r_out_valid, r_out_mis, r_out_last;
    t_idx  r_out_row, r_out_col;
    t_out  r_out_value;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= t_dim'(MAX_DIM);
            r_cols_a <= t_dim'(MAX_DIM);
            r_rows_b <= t_dim'(MAX_DIM);
            r_cols_b <= t_dim'(MAX_DIM);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_ROWS_A: r_rows_a <= i_cfg_data;
                REG_COLS_A: r_cols_a <= i_cfg_data;
                REG_ROWS_B: r_rows_b <= i_cfg_data;
                REG_COLS_B: r_cols_b <= i_cfg_data;
            endcase
        end
    end

    assign ra = eff_dim(r_rows_a);
    assign ca = eff_dim(r_cols_a);
    assign rb = eff_dim(r_rows_b);
    assign cb = eff_dim(r_cols_b);

    // input decode
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        wr.wr_a = 1'b0;
        wr.wr_b = 1'b0;
        start   = 1'b0;
        wr.addr = elem_addr(i_s_axis_tdata[2:0], i_s_axis_tdata[5:3]);
        wr.data = t_elem'(signed'(i_s_axis_tdata[6 +: IN_VAL_W]));
        if (in_xfer) begin
            unique case (i_s_axis_tuser)
                ACT_WRITE_A: wr.wr_a = 1'b1;
                ACT_WRITE_B: wr.wr_b = 1'b1;
                ACT_COMPUTE: start   = 1'b1;
                default:     start   = 1'b0;
            endcase
        end
    end

    mme_store u_store (
        .i_clk    (i_clk),
        .i_wr     (wr),
        .i_rd     (rd),
        .o_a_data (a_rd),
        .o_b_data (b_rd)
    );

    // output slot and last element of the run
    assign slot_free = !r_out_valid || i_m_axis_tready;
    assign last_elem = ({1'b0, r_i} + 1'b1 == ra) && ({1'b0, r_j} + 1'b1 == cb);

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
    end

    // sequencer: issue inner-product reads, then hand the sum to the output, or report a dimension mismatch
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        rd.en     = 1'b0;
        rd.addr_a = elem_addr(r_i, r_k);
        rd.addr_b = elem_addr(r_k, r_j);
        load_out  = 1'b0;
        load_err  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_i = '0;
                    n_j = '0;
                    n_k = '0;
                    n_state = (ca != rb) ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                rd.en = 1'b1;
                if ({1'b0, r_k} + 1'b1 == ca) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_WAIT: begin
                if (r_acc_done && slot_free) begin
                    load_out = 1'b1;
                    if (last_elem) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RUN;
                        if ({1'b0, r_j} + 1'b1 == cb) begin
                            n_j = '0;
                            n_i = r_i + 1'b1;
                        end else begin
                            n_j = r_j + 1'b1;
                        end
                    end
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    load_err = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    // multiply-accumulate pipeline tags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_p1_valid <= rd.en;
            r_p2_valid <= r_p1_valid;
            if (load_out) begin
                r_acc_done <= 1'b0;
            end else if (r_p2_valid && r_p2_last) begin
                r_acc_done <= 1'b1;
            end
        end
        r_p1_first <= (r_k == '0);
        r_p1_last  <= ({1'b0, r_k} + 1'b1 == ca);
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
    end

    // product then accumulate at full precision
    always_ff @(posedge i_clk) begin
        if (r_p1_valid) begin
            r_prod <= a_rd * b_rd;
        end
        if (r_p2_valid) begin
            r_acc <= r_p2_first ? t_acc'(r_prod) : r_acc + t_acc'(r_prod);
        end
    end

    // saturate to 32 bits
    always_comb begin
        if (r_acc > SAT_MAX) begin
            sat_value = t_out'(SAT_MAX);
        end else if (r_acc < SAT_MIN) begin
            sat_value = t_out'(SAT_MIN);
        end else begin
            sat_value = t_out'(r_acc);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out || load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_row   <= r_i;
            r_out_col   <= r_j;
            r_out_value <= sat_value;
            r_out_mis   <= 1'b0;
            r_out_last  <= last_elem;
        end else if (load_err) begin
            r_out_row   <= '0;
            r_out_col   <= '0;
            r_out_value <= '0;
            r_out_mis   <= 1'b1;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_value, r_out_col, r_out_row};
    assign o_m_axis_tuser  = r_out_mis;
    assign o_m_axis_tlast  = r_out_last;

`ifndef NO_ASSERTIONS
    // no sum may be pending while a new element is being issued
    a_no_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> !r_acc_done)
        else $error("finished sum pending during issue");

    // a finished sum only follows the last inner-product term
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_acc_done) |-> $past(r_p2_valid && r_p2_last))
        else $error("sum marked done without its last term");

    // an error result always closes the run
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> o_m_axis_tlast)
        else $error("mismatch result not marked last");

    // a handed-over sum appears on the output in the next cycle
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (o_m_axis_tvalid && !o_m_axis_tuser))
        else $error("product element lost at output register");
`endif

endmodule
